### src/rcsd_pkg.sv
// shared types, constants and the id to slot table for the satellite frame decoder
// no dependencies; used by every module under src
package rcsd_pkg;

  localparam int FRAME_BYTES   = 32;
  localparam int CHANNEL_COUNT = 8;
  localparam int OUT_SLOTS     = 8;
  localparam int QUEUE_DEPTH   = 2;

  localparam int COUNT_W = $clog2(FRAME_BYTES + 1);
  localparam int IDX_W   = $clog2(FRAME_BYTES);
  localparam int SLOT_W  = $clog2(OUT_SLOTS);
  localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

  localparam int CHAN_W  = 11;
  localparam int VALUE_W = 10;
  localparam int OFFS_W  = 10;
  localparam int LINK_W  = 8;
  localparam int TIME_W  = 32;
  localparam int CFGI_W  = 2;

  localparam int WORD_COUNT  = FRAME_BYTES / 2;
  localparam int HEADER_WORD = FRAME_BYTES / 4;

  localparam logic [COUNT_W-1:0] FRAME_BYTES_C = COUNT_W'(FRAME_BYTES);
  localparam logic [QCNT_W-1:0]  QUEUE_DEPTH_C = QCNT_W'(QUEUE_DEPTH);

  localparam logic [TIME_W-1:0] FRAME_GAP_RST    = 32'd5000;
  localparam logic [TIME_W-1:0] LINK_TIMEOUT_RST = 32'd50000;
  localparam logic [OFFS_W-1:0] FIRST_OFFS_RST   = 10'd988;
  localparam logic [OFFS_W-1:0] OTHER_OFFS_RST   = 10'd1012;

  typedef enum logic [CFGI_W-1:0] {
    CFG_FRAME_GAP    = 2'd0,
    CFG_LINK_TIMEOUT = 2'd1,
    CFG_FIRST_OFFSET = 2'd2,
    CFG_OTHER_OFFSET = 2'd3
  } rcsd_cfg_idx_t;

  typedef struct packed {
    logic [TIME_W-1:0] frame_gap_us;
    logic [TIME_W-1:0] link_timeout_us;
    logic [OFFS_W-1:0] first_channel_offset;
    logic [OFFS_W-1:0] other_channel_offset;
  } rcsd_cfg_t;

  // one classified request handed from the front to the back
  typedef struct packed {
    logic                         decode;
    logic [LINK_W-1:0]            link;
    logic [FRAME_BYTES-1:0][7:0]  frame;
  } rcsd_job_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
  } rcsd_slot_t;

  localparam logic [5:0] ID_FIRST    = 6'd0;

  function automatic rcsd_slot_t slot_of(input logic [5:0] id);
    rcsd_slot_t r;
    r.hit  = 1'b1;
    r.slot = '0;
    unique case (id)
      6'd0:    r.slot = SLOT_W'(2);
      6'd1:    r.slot = SLOT_W'(0);
      6'd2:    r.slot = SLOT_W'(1);
      6'd3:    r.slot = SLOT_W'(3);
      6'd4:    r.slot = SLOT_W'(4);
      6'd5:    r.slot = SLOT_W'(5);
      6'd7:    r.slot = SLOT_W'(6);
      6'd8:    r.slot = SLOT_W'(7);
      default: r.hit  = 1'b0;
    endcase
    return r;
  endfunction

endpackage

### src/rc_satellite_frame_decoder.sv
// Receiver-satellite serial frame decoder. Each input request is a received byte
// (command 0) or a status poll (command 1) stamped with a free-running microsecond
// time; every request yields exactly one result carrying the eight channel slots,
// the link counter and a flag telling whether that request decoded a frame. A byte
// arriving more than frame_gap_us after the previous one starts a new frame, and a
// complete 32-byte frame is decoded at that moment. One request is taken per clock
// cycle while in_ready is high; the front end classifies it in the accepting cycle,
// a two-entry queue separates it from the back end, and the back end decodes all
// words of the frame in a single step into its output register, so a request passes
// through a queue entry and then the output register. Throughput is set by the
// output register: while the consumer holds out_ready low the queue fills and
// in_ready drops after two further requests. Configuration writes are accepted in
// any cycle and belong to idle periods.
// depends on rcsd_pkg, rcsd_front, rcsd_queue, rcsd_back
module rc_satellite_frame_decoder (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rcsd_pkg::CFGI_W-1:0]         cfg_index,
  input  logic [31:0]                         cfg_data,
  // request channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                command,
  input  logic [7:0]                          data_byte,
  input  logic [rcsd_pkg::TIME_W-1:0]         now_us,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [rcsd_pkg::CHAN_W-1:0]         throttle,
  output logic [rcsd_pkg::CHAN_W-1:0]         roll,
  output logic [rcsd_pkg::CHAN_W-1:0]         pitch,
  output logic [rcsd_pkg::CHAN_W-1:0]         yaw,
  output logic [rcsd_pkg::CHAN_W-1:0]         mode_channel,
  output logic [rcsd_pkg::CHAN_W-1:0]         aux_one,
  output logic [rcsd_pkg::CHAN_W-1:0]         aux_two,
  output logic [rcsd_pkg::CHAN_W-1:0]         aux_three,
  output logic [rcsd_pkg::LINK_W-1:0]         link_count,
  output logic                                frame_decoded
);

  rcsd_pkg::rcsd_cfg_t  cfg;
  rcsd_pkg::rcsd_job_t  front_job;
  rcsd_pkg::rcsd_job_t  back_job;
  logic                 front_valid;
  logic                 front_ready;
  logic                 back_valid;
  logic                 back_ready;
  logic [rcsd_pkg::OUT_SLOTS-1:0][rcsd_pkg::CHAN_W-1:0] chan;

  // configuration registers, never back-pressured
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_gap_us         <= rcsd_pkg::FRAME_GAP_RST;
      cfg.link_timeout_us      <= rcsd_pkg::LINK_TIMEOUT_RST;
      cfg.first_channel_offset <= rcsd_pkg::FIRST_OFFS_RST;
      cfg.other_channel_offset <= rcsd_pkg::OTHER_OFFS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (rcsd_pkg::rcsd_cfg_idx_t'(cfg_index))
        rcsd_pkg::CFG_FRAME_GAP:    cfg.frame_gap_us         <= cfg_data;
        rcsd_pkg::CFG_LINK_TIMEOUT: cfg.link_timeout_us      <= cfg_data;
        rcsd_pkg::CFG_FIRST_OFFSET: cfg.first_channel_offset <= cfg_data[rcsd_pkg::OFFS_W-1:0];
        rcsd_pkg::CFG_OTHER_OFFSET: cfg.other_channel_offset <= cfg_data[rcsd_pkg::OFFS_W-1:0];
      endcase
    end
  end

  // front: gap detection, byte store, link counter
  rcsd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .data_byte (data_byte),
    .now_us    (now_us),
    .job_valid (front_valid),
    .job       (front_job),
    .job_ready (front_ready)
  );

  // decoupling queue, lets the front keep taking requests while a result waits
  rcsd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (front_job),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_data   (back_job)
  );

  // back: word decode into channel slots, result register
  rcsd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .job_valid     (back_valid),
    .job_ready     (back_ready),
    .job           (back_job),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .chan          (chan),
    .link_count    (link_count),
    .frame_decoded (frame_decoded)
  );

  // slot order on the ports
  assign throttle     = chan[0];
  assign roll         = chan[1];
  assign pitch        = chan[2];
  assign yaw          = chan[3];
  assign mode_channel = chan[4];
  assign aux_one      = chan[5];
  assign aux_two      = chan[6];
  assign aux_three    = chan[7];

  // a decode clears the link counter before counting the byte that caused it
  a_decode_link_one: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_decoded) |-> (link_count == 8'd1))
    else $error("decoded frame with link count other than one");

  // the front only stalls when the queue holds a pending request
  a_stall_needs_queue: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> back_valid)
    else $error("request stalled with empty queue");

  // channel slots move only with a result that decoded a frame
  a_chan_moves_on_decode: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(throttle)) |-> (out_valid && frame_decoded))
    else $error("channel changed without a decoded frame");

endmodule

### src/rcsd_front.sv
// front end: frame timing, byte collection and link counter; classifies each request
// depends on rcsd_pkg
module rcsd_front (
  input  logic                          clk,
  input  logic                          rst,
  input  rcsd_pkg::rcsd_cfg_t           cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          command,
  input  logic [7:0]                    data_byte,
  input  logic [rcsd_pkg::TIME_W-1:0]   now_us,
  output logic                          job_valid,
  output rcsd_pkg::rcsd_job_t           job,
  input  logic                          job_ready
);

  logic [rcsd_pkg::TIME_W-1:0]             last_byte_time;
  logic [rcsd_pkg::COUNT_W-1:0]            byte_count;
  logic [rcsd_pkg::LINK_W-1:0]             link_counter;
  logic [rcsd_pkg::FRAME_BYTES-1:0][7:0]   frame_buffer;

  logic [rcsd_pkg::TIME_W-1:0]  elapsed;
  logic                         gap;
  logic                         timed_out;
  logic                         decode;
  logic                         store;
  logic                         accept;
  logic [rcsd_pkg::COUNT_W-1:0] base;
  logic [rcsd_pkg::COUNT_W-1:0] byte_count_next;
  logic [rcsd_pkg::LINK_W-1:0]  link_counter_next;

  assign in_ready  = job_ready;
  assign job_valid = in_valid;
  assign accept    = in_valid & job_ready;

  always_comb begin
    elapsed   = now_us - last_byte_time;
    gap       = elapsed > cfg.frame_gap_us;
    timed_out = elapsed > cfg.link_timeout_us;
    decode    = !command && gap && (byte_count == rcsd_pkg::FRAME_BYTES_C);
    base      = gap ? '0 : byte_count;
    store     = base < rcsd_pkg::FRAME_BYTES_C;
    byte_count_next = store ? base + 1'b1 : base;
    if (command) begin
      link_counter_next = timed_out ? '0 : link_counter;
    end else begin
      link_counter_next = (decode ? '0 : link_counter) + 1'b1;
    end
    job.decode = decode;
    job.link   = link_counter_next;
    job.frame  = frame_buffer;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_byte_time <= '0;
      byte_count     <= '0;
      link_counter   <= '0;
    end else if (accept) begin
      link_counter <= link_counter_next;
      if (!command) begin
        last_byte_time <= now_us;
        byte_count     <= byte_count_next;
      end
    end
  end

  // bytes past a full frame are dropped
  always_ff @(posedge clk) begin
    if (accept && !command && store) begin
      frame_buffer[base[rcsd_pkg::IDX_W-1:0]] <= data_byte;
    end
  end

endmodule

### src/rcsd_queue.sv
// two-entry request queue between front and back
// depends on rcsd_pkg
module rcsd_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  rcsd_pkg::rcsd_job_t  push_data,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output rcsd_pkg::rcsd_job_t  pop_data
);

  rcsd_pkg::rcsd_job_t         entries [rcsd_pkg::QUEUE_DEPTH];
  logic [rcsd_pkg::QPTR_W-1:0] wr_ptr;
  logic [rcsd_pkg::QPTR_W-1:0] rd_ptr;
  logic [rcsd_pkg::QCNT_W-1:0] count;
  logic                        push;
  logic                        pop;

  function automatic logic [rcsd_pkg::QCNT_W-1:0] QCNT_ONE(input logic b);
    return {{(rcsd_pkg::QCNT_W-1){1'b0}}, b};
  endfunction

  assign push_ready = count != rcsd_pkg::QUEUE_DEPTH_C;
  assign pop_valid  = count != '0;
  assign pop_data   = entries[rd_ptr];
  assign push       = push_valid & push_ready;
  assign pop        = pop_valid & pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + QCNT_ONE(push) - QCNT_ONE(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

endmodule

### src/rcsd_back.sv
// back end: frame word decode into channel slots and the result register
// depends on rcsd_pkg
module rcsd_back (
  input  logic                                          clk,
  input  logic                                          rst,
  input  rcsd_pkg::rcsd_cfg_t                           cfg,
  input  logic                                          job_valid,
  output logic                                          job_ready,
  input  rcsd_pkg::rcsd_job_t                           job,
  output logic                                          out_valid,
  input  logic                                          out_ready,
  output logic [rcsd_pkg::OUT_SLOTS-1:0][rcsd_pkg::CHAN_W-1:0] chan,
  output logic [rcsd_pkg::LINK_W-1:0]                   link_count,
  output logic                                          frame_decoded
);

  logic [rcsd_pkg::OUT_SLOTS-1:0][rcsd_pkg::CHAN_W-1:0] chan_next;
  logic pop;

  assign job_ready = !out_valid || out_ready;
  assign pop       = job_valid && job_ready;

  // per slot, the last matching word of the frame wins
  always_comb begin
    logic [15:0]               word;
    logic [rcsd_pkg::OFFS_W-1:0] offs;
    rcsd_pkg::rcsd_slot_t      hit;
    chan_next = chan;
    for (int s = 0; s < rcsd_pkg::OUT_SLOTS; s++) begin
      for (int w = 1; w < rcsd_pkg::WORD_COUNT; w++) begin
        word = {job.frame[2*w], job.frame[2*w+1]};
        hit  = rcsd_pkg::slot_of(word[15:10]);
        offs = (word[15:10] == rcsd_pkg::ID_FIRST) ? cfg.first_channel_offset
                                                   : cfg.other_channel_offset;
        if (w != rcsd_pkg::HEADER_WORD && hit.hit && word[9:0] != '0 &&
            hit.slot == rcsd_pkg::SLOT_W'(s) && int'(hit.slot) < rcsd_pkg::CHANNEL_COUNT) begin
          chan_next[s] = rcsd_pkg::CHAN_W'(word[9:0]) + rcsd_pkg::CHAN_W'(offs);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      chan      <= '0;
    end else if (pop) begin
      out_valid <= 1'b1;
      if (job.decode) chan <= chan_next;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      link_count    <= job.link;
      frame_decoded <= job.decode;
    end
  end

endmodule

### verif/rc_satellite_frame_decoder_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for rc_satellite_frame_decoder: byte and poll requests are
// tracked by a behavioural frame decoder and every result is compared field by field
// depends on rcsd_pkg and rc_satellite_frame_decoder
module rc_satellite_frame_decoder_tb;
  import rcsd_pkg::*;

  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_POLL = 1'b1
  } request_kind_t;

  // channel ids carried in bits 15..10 of a frame word
  typedef enum logic [5:0] {
    CID_PITCH     = 6'd0,
    CID_THROTTLE  = 6'd1,
    CID_ROLL      = 6'd2,
    CID_YAW       = 6'd3,
    CID_MODE      = 6'd4,
    CID_AUX_ONE   = 6'd5,
    CID_SPARE     = 6'd6,
    CID_AUX_TWO   = 6'd7,
    CID_AUX_THREE = 6'd8
  } channel_id_t;

  // one result as the block should present it
  typedef struct packed {
    logic [OUT_SLOTS-1:0][CHAN_W-1:0] chan;
    logic [LINK_W-1:0]                link;
    logic                             decoded;
  } channel_report_t;

  typedef logic [FRAME_BYTES/2-1:0][15:0] frame_words_t;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  rcsd_cfg_idx_t        cfg_index = CFG_FRAME_GAP;
  logic [31:0]          cfg_data  = '0;

  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic                 command   = CMD_BYTE;
  logic [7:0]           data_byte = '0;
  logic [TIME_W-1:0]    now_us    = '0;

  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [CHAN_W-1:0]    throttle, roll, pitch, yaw;
  logic [CHAN_W-1:0]    mode_channel, aux_one, aux_two, aux_three;
  logic [LINK_W-1:0]    link_count;
  logic                 frame_decoded;

  rc_satellite_frame_decoder u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .data_byte     (data_byte),
    .now_us        (now_us),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .throttle      (throttle),
    .roll          (roll),
    .pitch         (pitch),
    .yaw           (yaw),
    .mode_channel  (mode_channel),
    .aux_one       (aux_one),
    .aux_two       (aux_two),
    .aux_three     (aux_three),
    .link_count    (link_count),
    .frame_decoded (frame_decoded)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // generous ceiling, far above the slowest legal run
  initial begin
    #1_000_000;
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // behavioural copy of the decoder: settings, frame store, timing and channels
  // ---------------------------------------------------------------------------
  logic [TIME_W-1:0] gap_us     = 32'd5000;
  logic [TIME_W-1:0] timeout_us = 32'd50000;
  logic [OFFS_W-1:0] first_offs = 10'd988;
  logic [OFFS_W-1:0] other_offs = 10'd1012;

  logic [7:0]        frame_store [FRAME_BYTES];
  int                stored_bytes = 0;
  logic [TIME_W-1:0] last_byte_us = '0;
  logic [LINK_W-1:0] link_bytes   = '0;
  logic [CHAN_W-1:0] slot_value [OUT_SLOTS] = '{default: '0};

  channel_report_t   channel_reports [$];
  channel_report_t   due;
  int                mismatches = 0;

  // stimulus side: link to the traffic shaping and the time base of sent bytes
  int                idle_pct      = 10;
  int                stall_pct     = 67;
  int                hold_request  = 0;
  int                hold_left     = 0;
  int                requests_sent = 0;
  logic [TIME_W-1:0] stim_byte_us  = '0;

  // advance the decoder copy by one request and return what the block must show
  function automatic channel_report_t track_decoder(input logic kind, input logic [7:0] b,
                                                    input logic [TIME_W-1:0] t);
    channel_report_t   res;
    logic [TIME_W-1:0] elapsed;
    logic [15:0]       word;
    int                slot;
    res = '0;
    elapsed = t - last_byte_us;   // modulo 2^32, so wrapped times still measure right
    if (kind == CMD_BYTE) begin
      if (elapsed > gap_us) begin
        // a full frame is decoded only once the next frame begins
        if (stored_bytes >= FRAME_BYTES) begin
          for (int w = 1; w < FRAME_BYTES / 2; w++) begin
            word = {frame_store[2*w], frame_store[2*w+1]};
            case (word[15:10])
              CID_THROTTLE:  slot = 0;
              CID_ROLL:      slot = 1;
              CID_PITCH:     slot = 2;
              CID_YAW:       slot = 3;
              CID_MODE:      slot = 4;
              CID_AUX_ONE:   slot = 5;
              CID_AUX_TWO:   slot = 6;
              CID_AUX_THREE: slot = 7;
              default:       slot = -1;
            endcase
            // mid-frame header, zero values and unmapped ids leave the slots alone;
            // a later word for the same slot simply overwrites an earlier one
            if (w != FRAME_BYTES / 4 && word[9:0] != '0 && slot >= 0 && slot < CHANNEL_COUNT)
              slot_value[slot] = CHAN_W'(word[9:0]) +
                CHAN_W'((word[15:10] == CID_PITCH) ? first_offs : other_offs);
          end
          link_bytes  = '0;
          res.decoded = 1'b1;
        end
        // an incomplete frame is just thrown away, link count kept
        stored_bytes = 0;
      end
      // bytes beyond a full frame are dropped
      if (stored_bytes < FRAME_BYTES) begin
        frame_store[stored_bytes] = b;
        stored_bytes++;
      end
      link_bytes   = link_bytes + 1'b1;
      last_byte_us = t;
    end else if (elapsed > timeout_us) begin
      link_bytes = '0;
    end
    for (int j = 0; j < OUT_SLOTS; j++)
      res.chan[j] = (j < CHANNEL_COUNT) ? slot_value[j] : '0;
    res.link = link_bytes;
    return res;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // request capture and result checking, both on the same edge, so ordering
  // between the two sides within a time step cannot matter
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        channel_reports.push_back(track_decoder(command, data_byte, now_us));
      if (out_valid && out_ready) begin
        if (channel_reports.size() == 0) begin
          mismatches++;
          $display("%0t ns: result arrived with no request outstanding", $time);
        end else begin
          due = channel_reports.pop_front();
          check_field("throttle",      32'(due.chan[0]), 32'(throttle));
          check_field("roll",          32'(due.chan[1]), 32'(roll));
          check_field("pitch",         32'(due.chan[2]), 32'(pitch));
          check_field("yaw",           32'(due.chan[3]), 32'(yaw));
          check_field("mode_channel",  32'(due.chan[4]), 32'(mode_channel));
          check_field("aux_one",       32'(due.chan[5]), 32'(aux_one));
          check_field("aux_two",       32'(due.chan[6]), 32'(aux_two));
          check_field("aux_three",     32'(due.chan[7]), 32'(aux_three));
          check_field("link_count",    32'(due.link),    32'(link_count));
          check_field("frame_decoded", 32'(due.decoded), 32'(frame_decoded));
        end
      end
    end
  end

  // result side: random stalls, plus a long hold-off counted here when asked for
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // one request, with a random idle gap in front; valid stays up until taken
  task automatic offer_request(input request_kind_t kind, input logic [7:0] b,
                               input logic [TIME_W-1:0] t);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid  <= 1'b1;
    command   <= kind;
    data_byte <= b;
    now_us    <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
  endtask

  // a time step no larger than the limit, the exact limit now and then
  function automatic logic [TIME_W-1:0] step_within(input logic [TIME_W-1:0] limit);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return limit;
    if (r < 80) return $urandom_range((limit < 2000) ? limit : 2000, 0);
    return $urandom_range(limit, 0);
  endfunction

  // a time step beyond the limit, mostly just past it, sometimes far past
  function automatic logic [TIME_W-1:0] step_past(input logic [TIME_W-1:0] limit);
    logic [TIME_W-1:0] room;
    // nothing lies beyond the largest limit, any step will do
    if (limit == TIME_MAX) return $urandom;
    room = TIME_MAX - limit - 1'b1;
    if ($urandom_range(9) == 0) return limit + 1'b1 + $urandom_range(room, 0);
    return limit + 1'b1 + $urandom_range((room < 3000) ? room : 3000, 0);
  endfunction

  function automatic logic [TIME_W-1:0] poll_delta();
    return $urandom_range(1) ? step_within(timeout_us) : step_past(timeout_us);
  endfunction

  // mostly mapped ids with live values, some zero values and unmapped ids
  function automatic frame_words_t random_words();
    frame_words_t fw;
    int unsigned  r;
    for (int w = 0; w < FRAME_BYTES / 2; w++) begin
      r = $urandom_range(99);
      if (w == 0 || w == FRAME_BYTES / 4) begin
        fw[w] = 16'($urandom);
      end else begin
        fw[w][15:10] = 6'((r < 80) ? $urandom_range(8) :
                          (r < 92) ? $urandom_range(15, 9) : $urandom_range(63, 16));
        fw[w][9:0]   = ($urandom_range(9) == 0) ? 10'd0 : 10'($urandom_range(1023, 1));
      end
    end
    return fw;
  endfunction

  // bytes of a frame, big-endian words; the first byte opens a new frame,
  // bytes past the frame length carry random filler
  task automatic send_frame(input frame_words_t words, input int len,
                            input logic [TIME_W-1:0] step_us);
    logic [7:0]        b;
    logic [TIME_W-1:0] t;
    for (int i = 0; i < len; i++) begin
      if (i >= FRAME_BYTES) b = 8'($urandom);
      else b = i[0] ? words[i/2][7:0] : words[i/2][15:8];
      if (i == 0) t = stim_byte_us + step_past(gap_us);
      else if (step_us != 0) t = stim_byte_us + step_us;
      else t = stim_byte_us + step_within(gap_us);
      offer_request(CMD_BYTE, b, t);
      stim_byte_us = t;
    end
  endtask

  // poll stamped relative to the last byte sent; its data byte is junk
  task automatic send_poll(input logic [TIME_W-1:0] delta);
    offer_request(CMD_POLL, 8'($urandom), stim_byte_us + delta);
  endtask

  // stop sending and let every outstanding result come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (channel_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input rcsd_cfg_idx_t idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // all four registers, written only with the block drained
  task automatic apply_config(input logic [TIME_W-1:0] gap, input logic [TIME_W-1:0] tmo,
                              input logic [OFFS_W-1:0] first, input logic [OFFS_W-1:0] other);
    wait_for_results();
    write_register(CFG_FRAME_GAP,    gap);
    write_register(CFG_LINK_TIMEOUT, tmo);
    // junk in the upper data bits must not reach the 10-bit offsets
    write_register(CFG_FIRST_OFFSET, {22'($urandom), first});
    write_register(CFG_OTHER_OFFSET, {22'($urandom), other});
    cfg_valid <= 1'b0;
    gap_us     = gap;
    timeout_us = tmo;
    first_offs = first;
    other_offs = other;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // hand-built frame covering every word rule, then overlong, timeout poll,
  // decode on gap, partial frame discard and a poll right at the timeout
  task automatic test_directed_cases();
    frame_words_t fw;
    fw[0]  = {CID_YAW, 10'd400};          // leading header, never decoded
    fw[1]  = {CID_THROTTLE, 10'd1023};    // largest value
    fw[2]  = {CID_ROLL, 10'd1};           // smallest live value
    fw[3]  = {CID_PITCH, 10'd512};        // first channel offset
    fw[4]  = {CID_YAW, 10'd0};            // zero value ignored
    fw[5]  = {CID_SPARE, 10'd77};         // unused id ignored
    fw[6]  = {6'd9, 10'd5};               // id just past the table
    fw[7]  = 16'hFFFF;                    // top bit set, all ones
    fw[8]  = {CID_AUX_THREE, 10'd999};    // mid-frame header, must leave aux_three at 0
    fw[9]  = {CID_MODE, 10'd200};
    fw[10] = {CID_AUX_ONE, 10'd1023};
    fw[11] = {CID_AUX_TWO, 10'd1};
    fw[12] = {CID_THROTTLE, 10'd10};      // later word wins over word 1
    fw[13] = {CID_PITCH, 10'd1023};       // later word wins, largest value plus the first offset
    fw[14] = {6'd15, 10'd9};
    fw[15] = {6'd16, 10'd300};            // bit 14 set
    // poll before any byte at all
    send_poll(32'd10);
    // start just below the wrap so the frame crosses zero; two surplus bytes dropped
    stim_byte_us = 32'hFFFF_C000;
    send_frame(fw, FRAME_BYTES + 2, 32'd600);
    // long silence: the poll clears the link counter, frame still waits
    send_poll(timeout_us + 32'd10000);
    // gap byte decodes the frame, three more make a partial frame
    send_frame(random_words(), 4, '0);
    // gap byte throws the partial frame away, no decode
    send_frame(random_words(), 1, '0);
    // silence of exactly the timeout keeps the counter
    send_poll(timeout_us);
  endtask

  // mostly clean frames with random content; partial and overlong frames,
  // polls either side of the timeout and stray bytes at random times
  task automatic test_random_traffic(input int count);
    int          start;
    int unsigned r;
    start = requests_sent;
    while (requests_sent - start < count) begin
      r = $urandom_range(99);
      if (r < 60) begin
        send_frame(random_words(), FRAME_BYTES, '0);
      end else if (r < 70) begin
        send_frame(random_words(), $urandom_range(FRAME_BYTES - 1, 1), '0);
      end else if (r < 80) begin
        send_frame(random_words(), $urandom_range(FRAME_BYTES + 8, FRAME_BYTES + 1), '0);
      end else if (r < 95) begin
        repeat ($urandom_range(3, 1)) send_poll(poll_delta());
      end else begin
        repeat ($urandom_range(4, 1)) begin
          stim_byte_us = stim_byte_us + $urandom;
          offer_request(CMD_BYTE, 8'($urandom), stim_byte_us);
        end
      end
    end
  endtask

  // result side blocked for a long stretch while requests keep coming, so the
  // queue fills and the input stalls; afterwards the sender waits for a full drain
  task automatic test_output_backpressure();
    int keep;
    wait_for_results();
    keep         = idle_pct;
    idle_pct     = 0;
    hold_request = 300;
    send_frame(random_words(), FRAME_BYTES, '0);
    repeat (4) send_poll(poll_delta());
    wait_for_results();
    send_frame(random_words(), FRAME_BYTES, '0);
    idle_pct = keep;
  endtask

  // no gap can ever open with the largest gap setting, so the link counter
  // runs past 255 and wraps while the frame store saturates
  task automatic test_link_wrap();
    apply_config(TIME_MAX, TIME_MAX, 10'h3FF, 10'h3FF);
    repeat (6) begin
      send_frame(random_words(), 45, '0);
      send_poll(poll_delta());
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // sender mostly busy, result side stalling often; reset settings
    test_directed_cases();
    test_random_traffic(320);
    test_output_backpressure();

    // roles swapped; smallest gap and timeout, offsets at both ends
    idle_pct  = 67;
    stall_pct = 10;
    apply_config('0, '0, '0, 10'h3FF);
    test_random_traffic(320);
    test_link_wrap();

    // no idling at all; moderate random timing, offsets swapped round
    idle_pct  = 0;
    stall_pct = 0;
    apply_config($urandom_range(20000, 1), $urandom_range(200000, 1000), 10'h3FF, '0);
    test_random_traffic(320);

    wait_for_results();
    // keep running to catch any stray result
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
